/* rtl/cdda_pkg.sv */
package cdda_pkg;

   localparam int DEF_FIRST_YEAR = 1900;
   localparam int DEF_LAST_YEAR  = 2030;

   localparam int Y_W      = 12;
   localparam int M_W      = 4;
   localparam int D_W      = 5;
   localparam int OFF_W    = 17;
   localparam int OUT_Y_W  = 11;
   localparam int OUT_S_W  = 16;
   localparam int DOY_W    = 9;
   localparam int DBY_W    = 21;
   localparam int REQ_W    = 64;
   localparam int RSP_W    = 56;

   localparam int Q_W         = Y_W - 2;
   localparam int RECIP25     = 1311;
   localparam int RECIP25_SH  = 15;
   localparam int INV25       = 41;
   localparam int INV25_MAX   = 40;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_NEXT_B,
      OP_CAP_A,
      OP_CAP_B,
      OP_CALC,
      OP_TEST,
      OP_REM,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic last_bit;
      logic rsp_free;
   } dp_status_type;

   function automatic logic div25(input logic [Q_W-1:0] x);
      logic [2*Q_W-1:0] pr;
      pr = {{Q_W{1'b0}}, x} * (2*Q_W)'(INV25);
      return pr[Q_W-1:0] <= Q_W'(INV25_MAX);
   endfunction

   function automatic logic leap_year(input logic [Y_W-1:0] y);
      logic [Q_W-1:0] q4;
      logic [Q_W-1:0] q16;
      q4  = y[Y_W-1:2];
      q16 = {2'b00, y[Y_W-1:4]};
      return (y[1:0] == 2'b00) && (!div25(q4) || ((y[3:2] == 2'b00) && div25(q16)));
   endfunction

   function automatic logic [D_W-1:0] month_len(input logic [M_W-1:0] m, input logic lp);
      logic [D_W-1:0] n;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                  n = 5'd30;
         4'd2:                                     n = lp ? 5'd29 : 5'd28;
         default:                                  n = 5'd0;
      endcase
      return n;
   endfunction

   function automatic logic [DOY_W-1:0] cum_days(input logic [M_W-1:0] m, input logic lp);
      logic [DOY_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      if (lp && (m > 4'd2)) begin
         n = n + 9'd1;
      end
      return n;
   endfunction

endpackage

/* rtl/cdda_ystart.sv */
module cdda_ystart #(
   parameter int FIRST_YEAR = cdda_pkg::DEF_FIRST_YEAR,
   parameter int LAST_YEAR  = cdda_pkg::DEF_LAST_YEAR,
   localparam int P0    = FIRST_YEAR - 1,
   localparam int P1    = LAST_YEAR,
   localparam int BASE  = 365 * P0 + P0 / 4 - P0 / 100 + P0 / 400,
   localparam int TOP   = 365 * P1 + P1 / 4 - P1 / 100 + P1 / 400 - BASE - 1,
   localparam int SER_W = $clog2(TOP + 1)
) (
   input  logic                       clock,
   input  logic [cdda_pkg::Y_W-1:0]   year,
   output logic [SER_W-1:0]           year_start
);

   localparam int PR_W = cdda_pkg::Q_W + 11;
   localparam int QH_W = PR_W - cdda_pkg::RECIP25_SH;

   logic [cdda_pkg::Y_W-1:0]   p;
   logic [PR_W-1:0]            pr100;
   logic [PR_W-1:0]            pr400;
   logic [cdda_pkg::DBY_W-1:0] sum;

   logic [cdda_pkg::DBY_W-1:0] p365_in, p365_ff;
   logic [cdda_pkg::Q_W-1:0]   q4_in, q4_ff;
   logic [QH_W-1:0]            q100_in, q100_ff;
   logic [QH_W-1:0]            q400_in, q400_ff;

   always_comb begin
      p       = year - cdda_pkg::Y_W'(1);
      p365_in = cdda_pkg::DBY_W'(p) * cdda_pkg::DBY_W'(365);
      q4_in   = p[cdda_pkg::Y_W-1:2];
      pr100   = PR_W'(q4_in) * PR_W'(cdda_pkg::RECIP25);
      pr400   = PR_W'(p[cdda_pkg::Y_W-1:4]) * PR_W'(cdda_pkg::RECIP25);
      q100_in = pr100[PR_W-1:cdda_pkg::RECIP25_SH];
      q400_in = pr400[PR_W-1:cdda_pkg::RECIP25_SH];
   end

   always_ff @(posedge clock) begin
      p365_ff <= p365_in;
      q4_ff   <= q4_in;
      q100_ff <= q100_in;
      q400_ff <= q400_in;
   end

   always_comb begin
      sum = p365_ff + cdda_pkg::DBY_W'(q4_ff) - cdda_pkg::DBY_W'(q100_ff)
            + cdda_pkg::DBY_W'(q400_ff) - cdda_pkg::DBY_W'(BASE);
      year_start = sum[SER_W-1:0];
   end

endmodule

/* rtl/cdda_dp.sv */
module cdda_dp #(
   parameter int FIRST_YEAR = cdda_pkg::DEF_FIRST_YEAR,
   parameter int LAST_YEAR  = cdda_pkg::DEF_LAST_YEAR
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cdda_pkg::dp_op_type            op,
   output cdda_pkg::dp_status_type        status,
   input  logic [cdda_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cdda_pkg::RSP_W-1:0]     rsp_tdata
);

   localparam int SPAN  = LAST_YEAR - FIRST_YEAR;
   localparam int P0    = FIRST_YEAR - 1;
   localparam int P1    = LAST_YEAR;
   localparam int BASE  = 365 * P0 + P0 / 4 - P0 / 100 + P0 / 400;
   localparam int TOP   = 365 * P1 + P1 / 4 - P1 / 100 + P1 / 400 - BASE - 1;
   localparam int SER_W = $clog2(TOP + 1);
   localparam int YB    = (SPAN > 0) ? $clog2(SPAN + 1) : 1;
   localparam int SUM_W = ((SER_W > cdda_pkg::OFF_W) ? SER_W : cdda_pkg::OFF_W) + 2;

   localparam int Y_W   = cdda_pkg::Y_W;
   localparam int M_W   = cdda_pkg::M_W;
   localparam int D_W   = cdda_pkg::D_W;
   localparam int DOY_W = cdda_pkg::DOY_W;

   logic [Y_W-1:0]                      year_a, year_b;
   logic [M_W-1:0]                      month_a, month_b;
   logic [D_W-1:0]                      day_a, day_b;
   logic signed [cdda_pkg::OFF_W-1:0]   day_offset;

   logic                lp_a, lp_b, ok_a, ok_b, lp_y;
   logic [D_W-1:0]      ml_a, ml_b;
   logic [SER_W-1:0]    ys;
   logic signed [SUM_W-1:0] tsum;
   logic [YB-1:0]       cand, knew;
   logic                take;
   logic [M_W-1:0]      mo;
   logic [DOY_W-1:0]    day9;

   logic [Y_W-1:0]                      yq_in, yq_ff;
   logic [Y_W-1:0]                      yb_in, yb_ff;
   logic [DOY_W-1:0]                    doy_a_in, doy_a_ff;
   logic [DOY_W-1:0]                    doy_b_in, doy_b_ff;
   logic                                rep_a_in, rep_a_ff;
   logic                                rep_b_in, rep_b_ff;
   logic signed [cdda_pkg::OFF_W-1:0]   off_in, off_ff;
   logic [SER_W-1:0]                    sa_in, sa_ff;
   logic [SER_W-1:0]                    sb_in, sb_ff;
   logic [SER_W-1:0]                    t_in, t_ff;
   logic [SER_W-1:0]                    diff_in, diff_ff;
   logic                                oor_in, oor_ff;
   logic                                before_in, before_ff;
   logic [YB-1:0]                       mask_in, mask_ff;
   logic [YB-1:0]                       k_in, k_ff;
   logic [DOY_W-1:0]                    rem_in, rem_ff;
   logic                                rsp_valid_in, rsp_valid_ff;
   logic [cdda_pkg::RSP_W-1:0]          rsp_data_in, rsp_data_ff;

   // request fields, lowest bit first
   assign year_a     = req_tdata[11:0];
   assign month_a    = req_tdata[15:12];
   assign day_a      = req_tdata[20:16];
   assign year_b     = req_tdata[32:21];
   assign month_b    = req_tdata[36:33];
   assign day_b      = req_tdata[41:37];
   assign day_offset = req_tdata[58:42];

   cdda_ystart #(
      .FIRST_YEAR (FIRST_YEAR),
      .LAST_YEAR  (LAST_YEAR)
   ) u_ystart (
      .clock      (clock),
      .year       (yq_ff),
      .year_start (ys)
   );

   always_comb begin
      lp_a = cdda_pkg::leap_year(year_a);
      lp_b = cdda_pkg::leap_year(year_b);
      ml_a = cdda_pkg::month_len(month_a, lp_a);
      ml_b = cdda_pkg::month_len(month_b, lp_b);
      ok_a = (year_a >= Y_W'(FIRST_YEAR)) && (year_a <= Y_W'(LAST_YEAR))
             && (ml_a != '0) && (day_a != '0) && (day_a <= ml_a);
      ok_b = (year_b >= Y_W'(FIRST_YEAR)) && (year_b <= Y_W'(LAST_YEAR))
             && (ml_b != '0) && (day_b != '0) && (day_b <= ml_b);

      cand = k_ff | mask_ff;
      take = (cand <= YB'(SPAN)) && (ys <= t_ff);
      knew = take ? cand : k_ff;

      tsum = $signed({{(SUM_W - SER_W){1'b0}}, sa_ff}) + SUM_W'(off_ff);

      lp_y = cdda_pkg::leap_year(yq_ff);
      mo   = M_W'(1);
      for (int i = 2; i <= 12; i++) begin
         if (rem_ff >= cdda_pkg::cum_days(M_W'(i), lp_y)) begin
            mo = M_W'(i);
         end
      end
      day9 = rem_ff - cdda_pkg::cum_days(mo, lp_y) + DOY_W'(1);
   end

   always_comb begin
      yq_in        = yq_ff;
      yb_in        = yb_ff;
      doy_a_in     = doy_a_ff;
      doy_b_in     = doy_b_ff;
      rep_a_in     = rep_a_ff;
      rep_b_in     = rep_b_ff;
      off_in       = off_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      t_in         = t_ff;
      diff_in      = diff_ff;
      oor_in       = oor_ff;
      before_in    = before_ff;
      mask_in      = mask_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (op)
         cdda_pkg::OP_LOAD: begin
            yq_in    = ok_a ? year_a : Y_W'(FIRST_YEAR);
            yb_in    = ok_b ? year_b : Y_W'(FIRST_YEAR);
            doy_a_in = ok_a ? cdda_pkg::cum_days(month_a, lp_a) + DOY_W'(day_a) - DOY_W'(1)
                            : '0;
            doy_b_in = ok_b ? cdda_pkg::cum_days(month_b, lp_b) + DOY_W'(day_b) - DOY_W'(1)
                            : '0;
            rep_a_in = !ok_a;
            rep_b_in = !ok_b;
            off_in   = day_offset;
         end
         cdda_pkg::OP_NEXT_B: begin
            yq_in = yb_ff;
         end
         cdda_pkg::OP_CAP_A: begin
            sa_in = ys + SER_W'(doy_a_ff);
         end
         cdda_pkg::OP_CAP_B: begin
            sb_in = ys + SER_W'(doy_b_ff);
         end
         cdda_pkg::OP_CALC: begin
            if (tsum[SUM_W-1]) begin
               t_in   = '0;
               oor_in = 1'b1;
            end else if (tsum > SUM_W'(TOP)) begin
               t_in   = SER_W'(TOP);
               oor_in = 1'b1;
            end else begin
               t_in   = tsum[SER_W-1:0];
               oor_in = 1'b0;
            end
            diff_in         = (sa_ff >= sb_ff) ? sa_ff - sb_ff : sb_ff - sa_ff;
            before_in       = sa_ff < sb_ff;
            mask_in         = '0;
            mask_in[YB-1]   = 1'b1;
            k_in            = '0;
            yq_in           = Y_W'(FIRST_YEAR + (1 << (YB - 1)));
         end
         cdda_pkg::OP_TEST: begin
            k_in    = knew;
            mask_in = mask_ff >> 1;
            yq_in   = Y_W'(FIRST_YEAR) + Y_W'(knew | (mask_ff >> 1));
         end
         cdda_pkg::OP_REM: begin
            rem_in = DOY_W'(t_ff - ys);
         end
         cdda_pkg::OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {rep_b_ff,
                            rep_a_ff,
                            cdda_pkg::OUT_S_W'(sa_ff),
                            before_ff,
                            cdda_pkg::OUT_S_W'(diff_ff),
                            oor_ff,
                            day9[D_W-1:0],
                            mo,
                            cdda_pkg::OUT_Y_W'(yq_ff)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      yq_ff       <= yq_in;
      yb_ff       <= yb_in;
      doy_a_ff    <= doy_a_in;
      doy_b_ff    <= doy_b_in;
      rep_a_ff    <= rep_a_in;
      rep_b_ff    <= rep_b_in;
      off_ff      <= off_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      t_ff        <= t_in;
      diff_ff     <= diff_in;
      oor_ff      <= oor_in;
      before_ff   <= before_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.last_bit = mask_ff[0];
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

`ifndef ASSERT_OFF
   a_rsp_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[14:11] >= 4'd1 && rsp_data_ff[14:11] <= 4'd12
                        && rsp_data_ff[19:15] != 5'd0))
      else $error("result date has a bad month or day");

   a_target_clamped: assert property (@(posedge clock) disable iff (reset)
      op == cdda_pkg::OP_CALC |=> t_ff <= SER_W'(TOP))
      else $error("shifted day number above range end");

   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(mask_ff))
      else $error("year search mask not one-hot");

   a_rem_in_year: assert property (@(posedge clock) disable iff (reset)
      op == cdda_pkg::OP_REM |=> rem_ff < DOY_W'(366))
      else $error("day within year out of range");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      op == cdda_pkg::OP_OUT |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending one");
`endif

endmodule

/* rtl/cdda_ctrl.sv */
module cdda_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  cdda_pkg::dp_status_type   status,
   output cdda_pkg::dp_op_type       op
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_NEXT_B,
      S_CAP_A,
      S_CAP_B,
      S_CALC,
      S_PROD,
      S_TEST,
      S_FIN,
      S_REM,
      S_OUT
   } state_type;

   state_type state_in, state_ff;
   logic      ready_in, ready_ff;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      op       = cdda_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               op       = cdda_pkg::OP_LOAD;
               state_in = S_NEXT_B;
               ready_in = 1'b0;
            end
         end
         S_NEXT_B: begin
            op       = cdda_pkg::OP_NEXT_B;
            state_in = S_CAP_A;
         end
         S_CAP_A: begin
            op       = cdda_pkg::OP_CAP_A;
            state_in = S_CAP_B;
         end
         S_CAP_B: begin
            op       = cdda_pkg::OP_CAP_B;
            state_in = S_CALC;
         end
         S_CALC: begin
            op       = cdda_pkg::OP_CALC;
            state_in = S_PROD;
         end
         S_PROD: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            op       = cdda_pkg::OP_TEST;
            state_in = status.last_bit ? S_FIN : S_PROD;
         end
         S_FIN: begin
            state_in = S_REM;
         end
         S_REM: begin
            op       = cdda_pkg::OP_REM;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               op       = cdda_pkg::OP_OUT;
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

/* rtl/calendar_date_day_arithmetic.sv */
// Gregorian date arithmetic on a day-number scale starting at FIRST_YEAR-01-01.
// Request channel (req_): two dates A and B and a signed day offset. Invalid
// dates are replaced by FIRST_YEAR-01-01 and flagged.
// Response channel (rsp_): A shifted by the offset (saturated to the year
// range and flagged), |A - B| in days, A-before-B, the day number of A and
// the two replacement flags. One response per request.
// One request is in work at a time. Its processing time is set mostly by
// the binary search for the year of the shifted date: each step waits for
// the registered output of the shared year-start unit, then does the compare.
// A finished response sits in the output register; the next request is
// accepted while it waits. If rsp_tready stays low, the following result
// holds inside the block until the register frees up.
// Reset (synchronous, active high) returns to idle with req_tready high
// and drops any pending response.
module calendar_date_day_arithmetic #(
   parameter int FIRST_YEAR = cdda_pkg::DEF_FIRST_YEAR,
   parameter int LAST_YEAR  = cdda_pkg::DEF_LAST_YEAR
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // year_a[11:0] month_a[15:12] day_a[20:16] year_b[32:21] month_b[36:33]
   // day_b[41:37] day_offset[58:42] zero[63:59]
   input  logic [cdda_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // shifted_year[10:0] shifted_month[14:11] shifted_day[19:15]
   // shift_out_of_range[20] day_difference[36:21] a_before_b[37]
   // serial_a[53:38] a_replaced[54] b_replaced[55]
   output logic [cdda_pkg::RSP_W-1:0]   rsp_tdata
);

   cdda_pkg::dp_op_type      op;
   cdda_pkg::dp_status_type  status;

   cdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   cdda_dp #(
      .FIRST_YEAR (FIRST_YEAR),
      .LAST_YEAR  (LAST_YEAR)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
